>>> rtl/core/lsc_pkg.sv
// Package for the largest strong component filter: table sizes, derived widths,
// item and result codes, and the command and status records between controller
// and datapath. Depends on nothing.
package lsc_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int MAX_EDGES   = 4096;
    localparam int ID_W        = 64;
    localparam int NODE_AW     = $clog2(MAX_NODES);
    localparam int NODE_CW     = $clog2(MAX_NODES + 1);
    localparam int EDGE_AW     = $clog2(MAX_EDGES);
    localparam int EDGE_CW     = $clog2(MAX_EDGES + 1);
    localparam int SCAN_W      = (NODE_CW > EDGE_CW) ? NODE_CW : EDGE_CW;
    localparam int STACK_DEPTH = MAX_NODES + MAX_EDGES + 1;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int STACK_W     = NODE_AW + 1;
    localparam int CUR_W       = $clog2(MAX_NODES + MAX_EDGES + 1);

    typedef enum logic [1:0] {
        K_NODE    = 2'd0,
        K_EDGE    = 2'd1,
        K_COMPUTE = 2'd2,
        K_READ    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RK_STATUS = 2'd0,
        RK_NODE   = 2'd1,
        RK_EDGE   = 2'd2,
        RK_NONE   = 2'd3
    } rkind_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_NODES = 2'd1,
        ST_UNKNOWN  = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    typedef enum logic [5:0] {
        OP_NOP,
        OP_LATCH,
        OP_NSCAN_RD,
        OP_NCMP,
        OP_NADD,
        OP_ECMP,
        OP_EADD,
        OP_CSTAT,
        OP_SCAN0,
        OP_VCLR,
        OP_P1_INIT,
        OP_P1_ORD,
        OP_P1_SKIP,
        OP_P1_START,
        OP_POP,
        OP_P1_PCHK,
        OP_P1_VISIT,
        OP_EDGE_RD,
        OP_P1_ECHK,
        OP_P2_INIT,
        OP_P2_ORD,
        OP_P2_FRD,
        OP_P2_START,
        OP_P2_DISC,
        OP_P2_ECHK,
        OP_P2_VCHK,
        OP_P2_DONE,
        OP_SEL_LA,
        OP_SEL_LB,
        OP_SEL_CHK,
        OP_R_START,
        OP_R_N1,
        OP_R_E1,
        OP_R_E2,
        OP_R_E3,
        OP_EMIT
    } op_t;

    typedef struct packed {
        op_t    op;
        rkind_t emit_kind;
    } cmd_t;

    typedef struct packed {
        logic lt_node;
        logic lt_edge;
        logic s_zero;
        logic sp_zero;
        logic node_hit;
        logic fin_entry;
        logic vis;
        logic tgt_hit;
        logic comp_fail;
        logic out_free;
        logic rd_node;
        logic rd_edge;
    } stat_t;

endpackage

>>> rtl/core/lsc_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module lsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/lsc_ctrl.sv
// Controller of the strong component filter: sequences loads, the two graph
// walks, edge selection and reads. Depends on lsc_pkg.
module lsc_ctrl
    import lsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] kind,
    input  stat_t      st,
    output cmd_t       cmd,
    output logic       in_stall
);

    typedef enum logic [5:0] {
        S_IDLE, S_N_SCAN, S_N_CMP, S_E_SCAN, S_E_CMP, S_C_STAT, S_C_CLR1,
        S_P1_OUTER, S_P1_OCHK, S_P1_POP, S_P1_PCHK, S_P1_VCHK, S_P1_ESCAN,
        S_P1_ECHK, S_C_CLR2, S_P2_OUTER, S_P2_FRD, S_P2_OCHK, S_P2_POP,
        S_P2_DISC, S_P2_ESCAN, S_P2_ECHK, S_P2_VCHK, S_SEL_RD, S_SEL_LA,
        S_SEL_LB, S_SEL_CHK, S_R_START, S_R_N1, S_R_E1, S_R_E2, S_R_E3, S_EMIT
    } state_t;

    state_t state_reg, state_next;
    rkind_t emit_reg, emit_next;
    op_t    op;

    always_comb
    begin
        state_next = state_reg;
        emit_next  = emit_reg;
        op         = OP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op = OP_LATCH;
                    unique case (kind_t'(kind))
                        K_NODE:    state_next = S_N_SCAN;
                        K_EDGE:    state_next = S_E_SCAN;
                        K_COMPUTE: state_next = S_C_STAT;
                        K_READ:    state_next = S_R_START;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_N_SCAN:
            begin
                if (st.lt_node)
                begin
                    op         = OP_NSCAN_RD;
                    state_next = S_N_CMP;
                end
                else
                begin
                    op         = OP_NADD;
                    state_next = S_IDLE;
                end
            end
            S_N_CMP:
            begin
                if (st.node_hit)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    op         = OP_NCMP;
                    state_next = S_N_SCAN;
                end
            end
            S_E_SCAN:
            begin
                if (st.lt_node)
                begin
                    op         = OP_NSCAN_RD;
                    state_next = S_E_CMP;
                end
                else
                begin
                    op         = OP_EADD;
                    state_next = S_IDLE;
                end
            end
            S_E_CMP:
            begin
                op         = OP_ECMP;
                state_next = S_E_SCAN;
            end
            S_C_STAT:
            begin
                op = OP_CSTAT;
                if (st.comp_fail)
                begin
                    emit_next  = RK_STATUS;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_C_CLR1;
                end
            end
            S_C_CLR1:
            begin
                if (st.lt_node)
                begin
                    op = OP_VCLR;
                end
                else
                begin
                    op         = OP_P1_INIT;
                    state_next = S_P1_OUTER;
                end
            end
            S_P1_OUTER:
            begin
                if (st.s_zero)
                begin
                    op         = OP_SCAN0;
                    state_next = S_C_CLR2;
                end
                else
                begin
                    op         = OP_P1_ORD;
                    state_next = S_P1_OCHK;
                end
            end
            S_P1_OCHK:
            begin
                if (st.vis)
                begin
                    op         = OP_P1_SKIP;
                    state_next = S_P1_OUTER;
                end
                else
                begin
                    op         = OP_P1_START;
                    state_next = S_P1_POP;
                end
            end
            S_P1_POP:
            begin
                if (st.sp_zero)
                begin
                    state_next = S_P1_OUTER;
                end
                else
                begin
                    op         = OP_POP;
                    state_next = S_P1_PCHK;
                end
            end
            S_P1_PCHK:
            begin
                op         = OP_P1_PCHK;
                state_next = st.fin_entry ? S_P1_POP : S_P1_VCHK;
            end
            S_P1_VCHK:
            begin
                if (st.vis)
                begin
                    state_next = S_P1_POP;
                end
                else
                begin
                    op         = OP_P1_VISIT;
                    state_next = S_P1_ESCAN;
                end
            end
            S_P1_ESCAN:
            begin
                if (st.lt_edge)
                begin
                    op         = OP_EDGE_RD;
                    state_next = S_P1_ECHK;
                end
                else
                begin
                    state_next = S_P1_POP;
                end
            end
            S_P1_ECHK:
            begin
                op         = OP_P1_ECHK;
                state_next = S_P1_ESCAN;
            end
            S_C_CLR2:
            begin
                if (st.lt_node)
                begin
                    op = OP_VCLR;
                end
                else
                begin
                    op         = OP_P2_INIT;
                    state_next = S_P2_OUTER;
                end
            end
            S_P2_OUTER:
            begin
                if (st.s_zero)
                begin
                    op         = OP_SCAN0;
                    state_next = S_SEL_RD;
                end
                else
                begin
                    op         = OP_P2_ORD;
                    state_next = S_P2_FRD;
                end
            end
            S_P2_FRD:
            begin
                op         = OP_P2_FRD;
                state_next = S_P2_OCHK;
            end
            S_P2_OCHK:
            begin
                if (st.vis)
                begin
                    state_next = S_P2_OUTER;
                end
                else
                begin
                    op         = OP_P2_START;
                    state_next = S_P2_POP;
                end
            end
            S_P2_POP:
            begin
                if (st.sp_zero)
                begin
                    op         = OP_P2_DONE;
                    state_next = S_P2_OUTER;
                end
                else
                begin
                    op         = OP_POP;
                    state_next = S_P2_DISC;
                end
            end
            S_P2_DISC:
            begin
                op         = OP_P2_DISC;
                state_next = S_P2_ESCAN;
            end
            S_P2_ESCAN:
            begin
                if (st.lt_edge)
                begin
                    op         = OP_EDGE_RD;
                    state_next = S_P2_ECHK;
                end
                else
                begin
                    state_next = S_P2_POP;
                end
            end
            S_P2_ECHK:
            begin
                op         = OP_P2_ECHK;
                state_next = st.tgt_hit ? S_P2_VCHK : S_P2_ESCAN;
            end
            S_P2_VCHK:
            begin
                op         = OP_P2_VCHK;
                state_next = S_P2_ESCAN;
            end
            S_SEL_RD:
            begin
                if (st.lt_edge)
                begin
                    op         = OP_EDGE_RD;
                    state_next = S_SEL_LA;
                end
                else
                begin
                    emit_next  = RK_STATUS;
                    state_next = S_EMIT;
                end
            end
            S_SEL_LA:
            begin
                op         = OP_SEL_LA;
                state_next = S_SEL_LB;
            end
            S_SEL_LB:
            begin
                op         = OP_SEL_LB;
                state_next = S_SEL_CHK;
            end
            S_SEL_CHK:
            begin
                op         = OP_SEL_CHK;
                state_next = S_SEL_RD;
            end
            S_R_START:
            begin
                op = OP_R_START;
                if (st.rd_node)
                begin
                    state_next = S_R_N1;
                end
                else if (st.rd_edge)
                begin
                    state_next = S_R_E1;
                end
                else
                begin
                    emit_next  = RK_NONE;
                    state_next = S_EMIT;
                end
            end
            S_R_N1:
            begin
                op         = OP_R_N1;
                emit_next  = RK_NODE;
                state_next = S_EMIT;
            end
            S_R_E1:
            begin
                op         = OP_R_E1;
                state_next = S_R_E2;
            end
            S_R_E2:
            begin
                op         = OP_R_E2;
                state_next = S_R_E3;
            end
            S_R_E3:
            begin
                op         = OP_R_E3;
                emit_next  = RK_EDGE;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (st.out_free)
                begin
                    op         = OP_EMIT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            emit_reg  <= RK_NONE;
        end
        else
        begin
            state_reg <= state_next;
            emit_reg  <= emit_next;
        end
    end

    assign cmd.op        = op;
    assign cmd.emit_kind = emit_reg;
    assign in_stall      = (state_reg != S_IDLE);

endmodule

>>> rtl/core/lsc_dp.sv
// Datapath of the strong component filter: the node, edge, walk and result
// memories, the walk counters and the output register. Depends on lsc_pkg, lsc_ram.
module lsc_dp
    import lsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    input  logic [1:0]       kind,
    input  logic [ID_W-1:0]  node_value,
    input  logic [ID_W-1:0]  edge_source,
    input  logic [ID_W-1:0]  edge_target,
    output stat_t            st,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       result_kind,
    output logic [1:0]       status_code,
    output logic [10:0]      component_nodes,
    output logic [12:0]      component_edges,
    output logic [ID_W-1:0]  out_node,
    output logic [ID_W-1:0]  out_source,
    output logic [ID_W-1:0]  out_target,
    output logic             last_one
);

    // Memory ports.
    logic                  node_we, node_re;
    logic [NODE_AW-1:0]    node_waddr, node_raddr;
    logic [ID_W-1:0]       node_wdata, node_rdata;
    logic                  edge_we, edge_re;
    logic [EDGE_AW-1:0]    edge_waddr, edge_raddr;
    logic [2*NODE_AW-1:0]  edge_wdata, edge_rdata;
    logic                  vis_we, vis_re;
    logic [NODE_AW-1:0]    vis_waddr, vis_raddr;
    logic                  vis_wdata, vis_rdata;
    logic                  stk_we, stk_re;
    logic [STACK_AW-1:0]   stk_waddr, stk_raddr;
    logic [STACK_W-1:0]    stk_wdata, stk_rdata;
    logic                  fin_we, fin_re;
    logic [NODE_AW-1:0]    fin_waddr, fin_raddr;
    logic [NODE_AW-1:0]    fin_wdata, fin_rdata;
    logic                  lab_we, lab_re;
    logic [NODE_AW-1:0]    lab_waddr, lab_raddr;
    logic [NODE_AW-1:0]    lab_wdata, lab_rdata;
    logic                  disc_we, disc_re;
    logic [NODE_AW-1:0]    disc_waddr, disc_raddr;
    logic [NODE_AW-1:0]    disc_wdata, disc_rdata;
    logic                  pick_we, pick_re;
    logic [EDGE_AW-1:0]    pick_waddr, pick_raddr;
    logic [EDGE_AW-1:0]    pick_wdata, pick_rdata;

    // Control registers.
    logic [NODE_CW-1:0]  node_fill_reg, node_fill_next;
    logic [EDGE_CW-1:0]  edge_fill_reg, edge_fill_next;
    logic [1:0]          err_reg, err_next;
    logic [NODE_CW-1:0]  best_count_reg, best_count_next;
    logic [EDGE_CW-1:0]  best_edges_reg, best_edges_next;
    logic [NODE_AW-1:0]  best_start_reg, best_start_next;
    logic [NODE_AW-1:0]  best_label_reg, best_label_next;
    logic [CUR_W-1:0]    cursor_reg, cursor_next;
    logic                out_valid_reg, out_valid_next;

    // Working registers.
    logic [ID_W-1:0]     id_a_reg, id_a_next;
    logic [ID_W-1:0]     id_b_reg, id_b_next;
    logic [ID_W-1:0]     src_id_reg, src_id_next;
    logic                fa_reg, fa_next;
    logic                fb_reg, fb_next;
    logic [NODE_AW-1:0]  idx_a_reg, idx_a_next;
    logic [NODE_AW-1:0]  idx_b_reg, idx_b_next;
    logic [SCAN_W-1:0]   scan_reg, scan_next;
    logic [NODE_CW-1:0]  s_reg, s_next;
    logic [SP_W-1:0]     sp_reg, sp_next;
    logic [NODE_CW-1:0]  fin_reg, fin_next;
    logic [NODE_CW-1:0]  dn_reg, dn_next;
    logic [NODE_CW-1:0]  start_reg, start_next;
    logic [NODE_AW-1:0]  lab_reg, lab_next;
    logic [NODE_AW-1:0]  cur_u_reg, cur_u_next;
    logic [NODE_AW-1:0]  tmp_reg, tmp_next;
    status_t             status_reg, status_next;

    // Output payload registers.
    rkind_t              o_kind_reg, o_kind_next;
    status_t             o_code_reg, o_code_next;
    logic [NODE_CW-1:0]  o_nodes_reg, o_nodes_next;
    logic [EDGE_CW-1:0]  o_edges_reg, o_edges_next;
    logic [ID_W-1:0]     o_node_reg, o_node_next;
    logic [ID_W-1:0]     o_src_reg, o_src_next;
    logic [ID_W-1:0]     o_tgt_reg, o_tgt_next;
    logic                o_last_reg, o_last_next;

    // Derived values.
    logic [NODE_AW-1:0]  e_src, e_tgt;
    logic [NODE_CW-1:0]  s_m1;
    logic [SP_W-1:0]     sp_m1;
    logic [NODE_CW-1:0]  comp_size;
    logic [CUR_W-1:0]    total;
    logic [CUR_W-1:0]    cursor_p1;
    status_t             comp_code;

    assign e_src     = edge_rdata[2*NODE_AW-1:NODE_AW];
    assign e_tgt     = edge_rdata[NODE_AW-1:0];
    assign s_m1      = s_reg - 1'b1;
    assign sp_m1     = sp_reg - 1'b1;
    assign comp_size = dn_reg - start_reg;
    assign total     = CUR_W'(best_count_reg) + CUR_W'(best_edges_reg);
    assign cursor_p1 = cursor_reg + 1'b1;

    always_comb
    begin
        if (node_fill_reg == '0)
        begin
            comp_code = ST_NO_NODES;
        end
        else if (err_reg[0])
        begin
            comp_code = ST_UNKNOWN;
        end
        else if (err_reg[1])
        begin
            comp_code = ST_OVERFLOW;
        end
        else
        begin
            comp_code = ST_OK;
        end
    end

    assign st.lt_node   = scan_reg < SCAN_W'(node_fill_reg);
    assign st.lt_edge   = scan_reg < SCAN_W'(edge_fill_reg);
    assign st.s_zero    = (s_reg == '0);
    assign st.sp_zero   = (sp_reg == '0);
    assign st.node_hit  = (node_rdata == id_a_reg);
    assign st.fin_entry = stk_rdata[0];
    assign st.vis       = vis_rdata;
    assign st.tgt_hit   = (e_tgt == cur_u_reg);
    assign st.comp_fail = (comp_code != ST_OK);
    assign st.out_free  = !out_valid_reg || !out_stall;
    assign st.rd_node   = cursor_reg < CUR_W'(best_count_reg);
    assign st.rd_edge   = cursor_reg < total;

    always_comb
    begin
        node_fill_next  = node_fill_reg;
        edge_fill_next  = edge_fill_reg;
        err_next        = err_reg;
        best_count_next = best_count_reg;
        best_edges_next = best_edges_reg;
        best_start_next = best_start_reg;
        best_label_next = best_label_reg;
        cursor_next     = cursor_reg;
        out_valid_next  = out_valid_reg && out_stall;
        id_a_next       = id_a_reg;
        id_b_next       = id_b_reg;
        src_id_next     = src_id_reg;
        fa_next         = fa_reg;
        fb_next         = fb_reg;
        idx_a_next      = idx_a_reg;
        idx_b_next      = idx_b_reg;
        scan_next       = scan_reg;
        s_next          = s_reg;
        sp_next         = sp_reg;
        fin_next        = fin_reg;
        dn_next         = dn_reg;
        start_next      = start_reg;
        lab_next        = lab_reg;
        cur_u_next      = cur_u_reg;
        tmp_next        = tmp_reg;
        status_next     = status_reg;
        o_kind_next     = o_kind_reg;
        o_code_next     = o_code_reg;
        o_nodes_next    = o_nodes_reg;
        o_edges_next    = o_edges_reg;
        o_node_next     = o_node_reg;
        o_src_next      = o_src_reg;
        o_tgt_next      = o_tgt_reg;
        o_last_next     = o_last_reg;

        node_we = 1'b0; node_re = 1'b0; node_waddr = '0; node_raddr = '0; node_wdata = '0;
        edge_we = 1'b0; edge_re = 1'b0; edge_waddr = '0; edge_raddr = '0; edge_wdata = '0;
        vis_we  = 1'b0; vis_re  = 1'b0; vis_waddr  = '0; vis_raddr  = '0; vis_wdata  = 1'b0;
        stk_we  = 1'b0; stk_re  = 1'b0; stk_waddr  = '0; stk_raddr  = '0; stk_wdata  = '0;
        fin_we  = 1'b0; fin_re  = 1'b0; fin_waddr  = '0; fin_raddr  = '0; fin_wdata  = '0;
        lab_we  = 1'b0; lab_re  = 1'b0; lab_waddr  = '0; lab_raddr  = '0; lab_wdata  = '0;
        disc_we = 1'b0; disc_re = 1'b0; disc_waddr = '0; disc_raddr = '0; disc_wdata = '0;
        pick_we = 1'b0; pick_re = 1'b0; pick_waddr = '0; pick_raddr = '0; pick_wdata = '0;

        unique case (cmd.op)
            OP_LATCH:
            begin
                id_a_next = (kind_t'(kind) == K_NODE) ? node_value : edge_source;
                id_b_next = edge_target;
                fa_next   = 1'b0;
                fb_next   = 1'b0;
                scan_next = '0;
                if (kind_t'(kind) != K_READ)
                begin
                    best_count_next = '0;
                    best_edges_next = '0;
                    best_start_next = '0;
                    cursor_next     = '0;
                end
            end
            OP_NSCAN_RD:
            begin
                node_re    = 1'b1;
                node_raddr = scan_reg[NODE_AW-1:0];
            end
            OP_NCMP:
            begin
                scan_next = scan_reg + 1'b1;
            end
            OP_NADD:
            begin
                if (node_fill_reg < NODE_CW'(MAX_NODES))
                begin
                    node_we        = 1'b1;
                    node_waddr     = node_fill_reg[NODE_AW-1:0];
                    node_wdata     = id_a_reg;
                    node_fill_next = node_fill_reg + 1'b1;
                end
                else
                begin
                    err_next[1] = 1'b1;
                end
            end
            OP_ECMP:
            begin
                if (node_rdata == id_a_reg)
                begin
                    fa_next    = 1'b1;
                    idx_a_next = scan_reg[NODE_AW-1:0];
                end
                if (node_rdata == id_b_reg)
                begin
                    fb_next    = 1'b1;
                    idx_b_next = scan_reg[NODE_AW-1:0];
                end
                scan_next = scan_reg + 1'b1;
            end
            OP_EADD:
            begin
                if (!(fa_reg && fb_reg))
                begin
                    err_next[0] = 1'b1;
                end
                else if (edge_fill_reg < EDGE_CW'(MAX_EDGES))
                begin
                    edge_we        = 1'b1;
                    edge_waddr     = edge_fill_reg[EDGE_AW-1:0];
                    edge_wdata     = {idx_a_reg, idx_b_reg};
                    edge_fill_next = edge_fill_reg + 1'b1;
                end
                else
                begin
                    err_next[1] = 1'b1;
                end
            end
            OP_CSTAT:
            begin
                status_next = comp_code;
                scan_next   = '0;
            end
            OP_SCAN0:
            begin
                scan_next = '0;
            end
            OP_VCLR:
            begin
                vis_we    = 1'b1;
                vis_waddr = scan_reg[NODE_AW-1:0];
                vis_wdata = 1'b0;
                scan_next = scan_reg + 1'b1;
            end
            OP_P1_INIT:
            begin
                s_next   = node_fill_reg;
                fin_next = '0;
            end
            OP_P1_ORD:
            begin
                vis_re    = 1'b1;
                vis_raddr = s_m1[NODE_AW-1:0];
            end
            OP_P1_SKIP:
            begin
                s_next = s_m1;
            end
            OP_P1_START:
            begin
                stk_we    = 1'b1;
                stk_waddr = '0;
                stk_wdata = {s_m1[NODE_AW-1:0], 1'b0};
                sp_next   = SP_W'(1);
                s_next    = s_m1;
            end
            OP_POP:
            begin
                stk_re    = 1'b1;
                stk_raddr = sp_m1[STACK_AW-1:0];
                sp_next   = sp_m1;
            end
            OP_P1_PCHK:
            begin
                cur_u_next = stk_rdata[NODE_AW:1];
                if (stk_rdata[0])
                begin
                    fin_we    = 1'b1;
                    fin_waddr = fin_reg[NODE_AW-1:0];
                    fin_wdata = stk_rdata[NODE_AW:1];
                    fin_next  = fin_reg + 1'b1;
                end
                else
                begin
                    vis_re    = 1'b1;
                    vis_raddr = stk_rdata[NODE_AW:1];
                end
            end
            OP_P1_VISIT:
            begin
                vis_we    = 1'b1;
                vis_waddr = cur_u_reg;
                vis_wdata = 1'b1;
                stk_we    = 1'b1;
                stk_waddr = sp_reg[STACK_AW-1:0];
                stk_wdata = {cur_u_reg, 1'b1};
                sp_next   = sp_reg + 1'b1;
                scan_next = '0;
            end
            OP_EDGE_RD:
            begin
                edge_re    = 1'b1;
                edge_raddr = scan_reg[EDGE_AW-1:0];
            end
            OP_P1_ECHK:
            begin
                if (e_src == cur_u_reg)
                begin
                    stk_we    = 1'b1;
                    stk_waddr = sp_reg[STACK_AW-1:0];
                    stk_wdata = {e_tgt, 1'b0};
                    sp_next   = sp_reg + 1'b1;
                end
                scan_next = scan_reg + 1'b1;
            end
            OP_P2_INIT:
            begin
                s_next   = fin_reg;
                dn_next  = '0;
                lab_next = '0;
            end
            OP_P2_ORD:
            begin
                fin_re    = 1'b1;
                fin_raddr = s_m1[NODE_AW-1:0];
            end
            OP_P2_FRD:
            begin
                cur_u_next = fin_rdata;
                vis_re     = 1'b1;
                vis_raddr  = fin_rdata;
                s_next     = s_m1;
            end
            OP_P2_START:
            begin
                vis_we     = 1'b1;
                vis_waddr  = cur_u_reg;
                vis_wdata  = 1'b1;
                stk_we     = 1'b1;
                stk_waddr  = '0;
                stk_wdata  = {1'b0, cur_u_reg};
                sp_next    = SP_W'(1);
                start_next = dn_reg;
            end
            OP_P2_DISC:
            begin
                cur_u_next = stk_rdata[NODE_AW-1:0];
                disc_we    = 1'b1;
                disc_waddr = dn_reg[NODE_AW-1:0];
                disc_wdata = stk_rdata[NODE_AW-1:0];
                dn_next    = dn_reg + 1'b1;
                lab_we     = 1'b1;
                lab_waddr  = stk_rdata[NODE_AW-1:0];
                lab_wdata  = lab_reg;
                scan_next  = '0;
            end
            OP_P2_ECHK:
            begin
                if (e_tgt == cur_u_reg)
                begin
                    tmp_next  = e_src;
                    vis_re    = 1'b1;
                    vis_raddr = e_src;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            OP_P2_VCHK:
            begin
                if (!vis_rdata)
                begin
                    vis_we    = 1'b1;
                    vis_waddr = tmp_reg;
                    vis_wdata = 1'b1;
                    stk_we    = 1'b1;
                    stk_waddr = sp_reg[STACK_AW-1:0];
                    stk_wdata = {1'b0, tmp_reg};
                    sp_next   = sp_reg + 1'b1;
                end
                scan_next = scan_reg + 1'b1;
            end
            OP_P2_DONE:
            begin
                if (comp_size > best_count_reg)
                begin
                    best_count_next = comp_size;
                    best_start_next = start_reg[NODE_AW-1:0];
                    best_label_next = lab_reg;
                end
                lab_next = lab_reg + 1'b1;
            end
            OP_SEL_LA:
            begin
                idx_a_next = e_src;
                idx_b_next = e_tgt;
                lab_re     = 1'b1;
                lab_raddr  = e_src;
            end
            OP_SEL_LB:
            begin
                fa_next   = (lab_rdata == best_label_reg);
                lab_re    = 1'b1;
                lab_raddr = idx_b_reg;
            end
            OP_SEL_CHK:
            begin
                if (fa_reg && (lab_rdata == best_label_reg))
                begin
                    pick_we         = 1'b1;
                    pick_waddr      = best_edges_reg[EDGE_AW-1:0];
                    pick_wdata      = scan_reg[EDGE_AW-1:0];
                    best_edges_next = best_edges_reg + 1'b1;
                end
                scan_next = scan_reg + 1'b1;
            end
            OP_R_START:
            begin
                disc_re    = 1'b1;
                disc_raddr = best_start_reg + cursor_reg[NODE_AW-1:0];
                pick_re    = 1'b1;
                pick_raddr = cursor_reg[EDGE_AW-1:0] - EDGE_AW'(best_count_reg);
            end
            OP_R_N1:
            begin
                node_re    = 1'b1;
                node_raddr = disc_rdata;
            end
            OP_R_E1:
            begin
                edge_re    = 1'b1;
                edge_raddr = pick_rdata;
            end
            OP_R_E2:
            begin
                node_re    = 1'b1;
                node_raddr = e_src;
            end
            OP_R_E3:
            begin
                src_id_next = node_rdata;
                node_re     = 1'b1;
                node_raddr  = e_tgt;
            end
            OP_EMIT:
            begin
                out_valid_next = 1'b1;
                o_kind_next    = cmd.emit_kind;
                o_code_next    = (cmd.emit_kind == RK_STATUS) ? status_reg : ST_OK;
                o_nodes_next   = best_count_reg;
                o_edges_next   = best_edges_reg;
                o_node_next    = '0;
                o_src_next     = '0;
                o_tgt_next     = '0;
                o_last_next    = 1'b0;
                if (cmd.emit_kind == RK_NODE)
                begin
                    o_node_next = node_rdata;
                    o_last_next = (cursor_p1 == CUR_W'(best_count_reg));
                    cursor_next = cursor_p1;
                end
                else if (cmd.emit_kind == RK_EDGE)
                begin
                    o_src_next  = src_id_reg;
                    o_tgt_next  = node_rdata;
                    o_last_next = (cursor_p1 == total);
                    cursor_next = cursor_p1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_fill_reg  <= '0;
            edge_fill_reg  <= '0;
            err_reg        <= '0;
            best_count_reg <= '0;
            best_edges_reg <= '0;
            best_start_reg <= '0;
            best_label_reg <= '0;
            cursor_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            node_fill_reg  <= node_fill_next;
            edge_fill_reg  <= edge_fill_next;
            err_reg        <= err_next;
            best_count_reg <= best_count_next;
            best_edges_reg <= best_edges_next;
            best_start_reg <= best_start_next;
            best_label_reg <= best_label_next;
            cursor_reg     <= cursor_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_a_reg    <= id_a_next;
        id_b_reg    <= id_b_next;
        src_id_reg  <= src_id_next;
        fa_reg      <= fa_next;
        fb_reg      <= fb_next;
        idx_a_reg   <= idx_a_next;
        idx_b_reg   <= idx_b_next;
        scan_reg    <= scan_next;
        s_reg       <= s_next;
        sp_reg      <= sp_next;
        fin_reg     <= fin_next;
        dn_reg      <= dn_next;
        start_reg   <= start_next;
        lab_reg     <= lab_next;
        cur_u_reg   <= cur_u_next;
        tmp_reg     <= tmp_next;
        status_reg  <= status_next;
        o_kind_reg  <= o_kind_next;
        o_code_reg  <= o_code_next;
        o_nodes_reg <= o_nodes_next;
        o_edges_reg <= o_edges_next;
        o_node_reg  <= o_node_next;
        o_src_reg   <= o_src_next;
        o_tgt_reg   <= o_tgt_next;
        o_last_reg  <= o_last_next;
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = o_kind_reg;
    assign status_code     = o_code_reg;
    assign component_nodes = o_nodes_reg;
    assign component_edges = o_edges_reg;
    assign out_node        = o_node_reg;
    assign out_source      = o_src_reg;
    assign out_target      = o_tgt_reg;
    assign last_one        = o_last_reg;

    lsc_ram #(.WIDTH(ID_W), .DEPTH(MAX_NODES)) u_node_mem (
        .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .re(node_re), .raddr(node_raddr), .rdata(node_rdata)
    );

    lsc_ram #(.WIDTH(2*NODE_AW), .DEPTH(MAX_EDGES)) u_edge_mem (
        .clk(clk), .we(edge_we), .waddr(edge_waddr), .wdata(edge_wdata),
        .re(edge_re), .raddr(edge_raddr), .rdata(edge_rdata)
    );

    lsc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_visit_mem (
        .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
        .re(vis_re), .raddr(vis_raddr), .rdata(vis_rdata)
    );

    lsc_ram #(.WIDTH(STACK_W), .DEPTH(STACK_DEPTH)) u_stack_mem (
        .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
        .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
    );

    lsc_ram #(.WIDTH(NODE_AW), .DEPTH(MAX_NODES)) u_finish_mem (
        .clk(clk), .we(fin_we), .waddr(fin_waddr), .wdata(fin_wdata),
        .re(fin_re), .raddr(fin_raddr), .rdata(fin_rdata)
    );

    lsc_ram #(.WIDTH(NODE_AW), .DEPTH(MAX_NODES)) u_label_mem (
        .clk(clk), .we(lab_we), .waddr(lab_waddr), .wdata(lab_wdata),
        .re(lab_re), .raddr(lab_raddr), .rdata(lab_rdata)
    );

    lsc_ram #(.WIDTH(NODE_AW), .DEPTH(MAX_NODES)) u_disc_mem (
        .clk(clk), .we(disc_we), .waddr(disc_waddr), .wdata(disc_wdata),
        .re(disc_re), .raddr(disc_raddr), .rdata(disc_rdata)
    );

    lsc_ram #(.WIDTH(EDGE_AW), .DEPTH(MAX_EDGES)) u_pick_mem (
        .clk(clk), .we(pick_we), .waddr(pick_waddr), .wdata(pick_wdata),
        .re(pick_re), .raddr(pick_raddr), .rdata(pick_rdata)
    );

endmodule

>>> rtl/core/largest_strong_component_filter_core.sv
// Top level of the largest strong component filter: joins the controller and the
// datapath. Depends on lsc_pkg, lsc_ctrl, lsc_dp (and lsc_ram below it).
//
// Usage. The input channel (in_valid / in_stall) carries one beat per item: kind
// selects load node, load edge, compute or read. The output channel
// (out_valid / out_stall) carries result beats; load items produce none,
// compute produces one status beat and every read produces one beat (a node,
// an edge, or "nothing left").
// Operation. The block takes one item at a time and holds in_stall high while it
// works on it. A load node item and a load edge item each search the stored
// nodes linearly through the single-read-port node memory; a node that is
// already stored ends the search early. A compute item clears the visit marks
// twice and walks the graph; every visited node scans the whole edge memory
// once per walk. Reset clears the fill counts, error flags and kept component;
// the memories need no clearing pass. A finished result sits in the output
// register and the next item is already accepted while it waits; if the
// receiver stalls, the block holds its next result until the register frees up.
module largest_strong_component_filter_core
    import lsc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [1:0]       kind,
    input  logic [ID_W-1:0]  node_value,
    input  logic [ID_W-1:0]  edge_source,
    input  logic [ID_W-1:0]  edge_target,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       result_kind,
    output logic [1:0]       status_code,
    output logic [10:0]      component_nodes,
    output logic [12:0]      component_edges,
    output logic [ID_W-1:0]  out_node,
    output logic [ID_W-1:0]  out_source,
    output logic [ID_W-1:0]  out_target,
    output logic             last_one
);

    cmd_t  cmd;
    stat_t st;

    // The controller steps through one item; the datapath carries out each
    // step's memory accesses and reports compare results back.
    lsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .kind     (kind),
        .st       (st),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    lsc_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .kind            (kind),
        .node_value      (node_value),
        .edge_source     (edge_source),
        .edge_target     (edge_target),
        .st              (st),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_kind     (result_kind),
        .status_code     (status_code),
        .component_nodes (component_nodes),
        .component_edges (component_edges),
        .out_node        (out_node),
        .out_source      (out_source),
        .out_target      (out_target),
        .last_one        (last_one)
    );

endmodule

>>> rtl/core/lsc_checker.sv
// Port-level checks of the strong component filter and the bind that attaches
// them to the top level. Depends on lsc_pkg.
module lsc_checker
    import lsc_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_stall,
    input logic             out_valid,
    input logic             out_stall,
    input logic [1:0]       result_kind,
    input logic [1:0]       status_code,
    input logic [10:0]      component_nodes,
    input logic [12:0]      component_edges,
    input logic [ID_W-1:0]  out_node,
    input logic [ID_W-1:0]  out_source,
    input logic [ID_W-1:0]  out_target,
    input logic             last_one
);

    // A stalled result beat stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its whole payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(result_kind) && $stable(status_code) &&
        $stable(component_nodes) && $stable(component_edges) && $stable(out_node) &&
        $stable(out_source) && $stable(out_target) && $stable(last_one))
        else $error("result payload changed while stalled");

    // Once an item is taken the block is busy on the next cycle.
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second item taken back to back");

    // Only status beats carry a status code.
    a_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind != RK_STATUS |-> status_code == ST_OK)
        else $error("status code on a non-status beat");

    // A failed compute leaves no component.
    a_fail_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == RK_STATUS && status_code != ST_OK
        |-> component_nodes == '0 && component_edges == '0 && !last_one)
        else $error("component reported after failed compute");

endmodule

bind largest_strong_component_filter_core lsc_checker u_lsc_checker (.*);
